[design/bwmv_pkg.sv]
// bwmv_pkg: types, codes and constants shared by the bf16 weight matrix-vector block.
// No dependencies; imported by bwmv_dadd, bf16_weight_matvec_top and the testbench.
package bwmv_pkg;

	localparam int MAX_IN_DEF  = 1024;
	localparam int MAX_OUT_DEF = 4096;

	localparam int IN_LEN_W   = 11;
	localparam int OUT_LEN_W  = 13;
	localparam int CFG_DATA_W = 13;

	localparam logic [IN_LEN_W-1:0]  IN_LEN_RST  = 11'd1024;
	localparam logic [OUT_LEN_W-1:0] OUT_LEN_RST = 13'd256;

	localparam logic CFG_IN_LENGTH  = 1'b0;
	localparam logic CFG_OUT_LENGTH = 1'b1;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_WEIGHT = 1'b1;

	localparam logic [15:0] BF16_EXP_MASK = 16'h7F80;
	localparam int          BF16_SHIFT    = 16;

	localparam logic [31:0] F32_QNAN    = 32'h7FC0_0000;
	localparam logic [30:0] F32_INF_MAG = 31'h7F80_0000;

	localparam int EXP_W = 11;
	localparam int SIG_W = 53;

	typedef struct packed {
		logic        op;
		logic [31:0] act_value;
		logic [9:0]  act_index;
		logic [15:0] weight_raw;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_value;
		logic [11:0] out_index;
		logic        last_output;
	} out_item_t;

	// Double value: sig holds the leading one at bit SIG_W-1, exp is its unbiased weight.
	typedef struct packed {
		logic                    nan;
		logic                    inf;
		logic                    zero;
		logic                    sign;
		logic signed [EXP_W-1:0] exp;
		logic [SIG_W-1:0]        sig;
	} dbl_t;

endpackage

[design/bwmv_ram.sv]
// bwmv_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the activation store.
module bwmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/bwmv_dadd.sv]
// bwmv_dadd: four-stage double-precision adder with round to nearest even.
// Depends on bwmv_pkg (dbl_t, EXP_W, SIG_W).
module bwmv_dadd import bwmv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  dbl_t acc,
	input  dbl_t addend,
	output logic done,
	output dbl_t sum
);

	localparam int GW = SIG_W + 3;
	localparam int SW = $clog2(GW);

	function automatic logic [SW-1:0] lzc(input logic [GW-1:0] v);
		logic [SW-1:0] n;
		n = '0;
		for (int i = 0; i < GW; i++) begin
			if (v[i]) begin
				n = SW'(GW - 1 - i);
			end
		end
		return n;
	endfunction

	// stage 1: order operands, align the smaller one
	logic             a_gt;
	dbl_t             big, sml, byp;
	logic             byp_en;
	logic [EXP_W-1:0] dexp;
	logic [GW-1:0]    sml_x, sml_al;
	logic             sml_st;

	always_comb begin
		a_gt = (acc.exp > addend.exp) || (acc.exp == addend.exp && acc.sig >= addend.sig);
		big = a_gt ? acc : addend;
		sml = a_gt ? addend : acc;
		dexp = big.exp - sml.exp;
		sml_x = {sml.sig, 3'b000};
		if (dexp >= EXP_W'(GW)) begin
			sml_al = '0;
			sml_st = 1'b1;
		end else begin
			sml_al = sml_x >> dexp[SW-1:0];
			sml_st = |(sml_x & ((GW'(1) << dexp[SW-1:0]) - GW'(1)));
		end
		byp = acc;
		byp_en = 1'b1;
		priority if (acc.nan || addend.nan || (acc.inf && addend.inf && acc.sign != addend.sign)) begin
			byp = '0;
			byp.nan = 1'b1;
		end else if (acc.inf || addend.inf) begin
			byp = '0;
			byp.inf = 1'b1;
			byp.sign = acc.inf ? acc.sign : addend.sign;
		end else if (addend.zero) begin
			byp = acc;
			if (acc.zero) begin
				byp.sign = acc.sign & addend.sign;
			end
		end else if (acc.zero) begin
			byp = addend;
		end else begin
			byp_en = 1'b0;
		end
	end

	logic                    v_s1, byp_en_s1, sign_s1, sub_s1;
	dbl_t                    byp_s1;
	logic [SIG_W-1:0]        big_s1;
	logic [GW-1:0]           al_s1;
	logic signed [EXP_W-1:0] exp_s1;

	logic                    v_s2, byp_en_s2, sign_s2;
	dbl_t                    byp_s2;
	logic [GW:0]             sum_s2;
	logic signed [EXP_W-1:0] exp_s2;

	logic                    v_s3, byp_en_s3, sign_s3, zero_s3;
	dbl_t                    byp_s3;
	logic [GW:0]             sum_s3;
	logic [SW-1:0]           lz_s3;
	logic signed [EXP_W-1:0] exp_s3;

	logic                    v_s4;
	dbl_t                    sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		byp_en_s1 <= byp_en;
		byp_s1    <= byp;
		big_s1    <= big.sig;
		al_s1     <= {sml_al[GW-1:1], sml_al[0] | sml_st};
		exp_s1    <= big.exp;
		sign_s1   <= big.sign;
		sub_s1    <= acc.sign ^ addend.sign;
	end

	// stage 2: add or subtract magnitudes
	always_ff @(posedge clk) begin
		byp_en_s2 <= byp_en_s1;
		byp_s2    <= byp_s1;
		exp_s2    <= exp_s1;
		sign_s2   <= sign_s1;
		if (sub_s1) begin
			sum_s2 <= {1'b0, big_s1, 3'b000} - {1'b0, al_s1};
		end else begin
			sum_s2 <= {1'b0, big_s1, 3'b000} + {1'b0, al_s1};
		end
	end

	// stage 3: leading-zero count
	always_ff @(posedge clk) begin
		byp_en_s3 <= byp_en_s2;
		byp_s3    <= byp_s2;
		exp_s3    <= exp_s2;
		sign_s3   <= sign_s2;
		sum_s3    <= sum_s2;
		zero_s3   <= (sum_s2 == '0);
		lz_s3     <= lzc(sum_s2[GW-1:0]);
	end

	// stage 4: normalise and round
	logic [GW-1:0]           nrm;
	logic signed [EXP_W-1:0] e4;
	logic                    up;
	logic [SIG_W:0]          rsig;
	dbl_t                    res;

	always_comb begin
		if (sum_s3[GW]) begin
			nrm = {sum_s3[GW:2], sum_s3[1] | sum_s3[0]};
			e4 = exp_s3 + EXP_W'(1);
		end else begin
			nrm = sum_s3[GW-1:0] << lz_s3;
			e4 = exp_s3 - EXP_W'(lz_s3);
		end
		up = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
		rsig = {1'b0, nrm[GW-1:3]} + (SIG_W+1)'(up);
		res = '0;
		res.sign = sign_s3;
		if (rsig[SIG_W]) begin
			res.sig = rsig[SIG_W:1];
			res.exp = e4 + EXP_W'(1);
		end else begin
			res.sig = rsig[SIG_W-1:0];
			res.exp = e4;
		end
		priority if (byp_en_s3) begin
			res = byp_s3;
		end else if (zero_s3) begin
			res = '0;
			res.zero = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= res;
	end

	assign done = v_s4;
	assign sum  = sum_s4;

	a_stage_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3, v_s4}))
		else $error("more than one addition in flight");
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##3 done)
		else $error("adder latency broken");
	a_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		done && !sum.nan && !sum.inf && !sum.zero |-> sum.sig[SIG_W-1])
		else $error("finite sum not normalised");

endmodule

[design/bf16_weight_matvec_top.sv]
// bf16_weight_matvec_top: bf16 weight by fp32 activation matrix-vector product.
// Depends on bwmv_pkg, bwmv_ram (activation store) and bwmv_dadd (accumulator adder).
//
// Input channel (in_valid/in_stall/in_data): op OP_LOAD writes act_value into the
// activation store at act_index; op OP_WEIGHT multiplies weight_raw by the stored
// activation at the running input position and adds it into a double accumulator.
// A weight transaction runs a store read, a 24x8 multiply, a normalise and then the
// double adder, whose loop through the accumulator sets the rate. in_stall is high
// while a weight works or its sum is rounded and loaded; no item is taken meanwhile.
// After in_length weights the sum is rounded to fp32 through ST_FR1 and ST_FR2 and
// loaded into the output register. The output register frees the input side at
// once; a new result waits in the rounding stage while out_stall holds the previous
// one. The user must write configuration (cfg_wr_en/cfg_index/cfg_data) only while
// the block is idle; the block itself does not enforce it.
// Reset clears the positions, the accumulator and sets in_length 1024 and
// out_length 256; the store holds nothing valid until written.
module bf16_weight_matvec_top import bwmv_pkg::*; #(
	parameter int MAX_IN  = MAX_IN_DEF,
	parameter int MAX_OUT = MAX_OUT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_IN);
	localparam int OW = $clog2(MAX_OUT);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_NORM = 7'b0000100,
		ST_ADD  = 7'b0001000,
		ST_WAIT = 7'b0010000,
		ST_FR1  = 7'b0100000,
		ST_FR2  = 7'b1000000
	} state_t;

	function automatic logic [4:0] lzc32(input logic [31:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				n = 5'(31 - i);
			end
		end
		return n;
	endfunction

	state_t                state_q;
	logic [IN_LEN_W-1:0]   in_len_q;
	logic [OUT_LEN_W-1:0]  out_len_q;
	logic [AW-1:0]         in_pos_q;
	logic [OW-1:0]         out_pos_q;
	logic                  emit_q, last_q;
	logic [OW-1:0]         idx_q;
	logic [15:0]           w_q;
	dbl_t                  acc_q, pd_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  in_acc, out_ld;
	logic [AW:0]           eff_in;
	logic [OW:0]           eff_out;
	logic                  in_last, out_last;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		if (in_len_q == '0) begin
			eff_in = (AW+1)'(1);
		end else if (32'(in_len_q) > MAX_IN) begin
			eff_in = (AW+1)'(MAX_IN);
		end else begin
			eff_in = (AW+1)'(in_len_q);
		end
		if (out_len_q == '0) begin
			eff_out = (OW+1)'(1);
		end else if (32'(out_len_q) > MAX_OUT) begin
			eff_out = (OW+1)'(MAX_OUT);
		end else begin
			eff_out = (OW+1)'(out_len_q);
		end
		in_last  = ({1'b0, in_pos_q} + (AW+1)'(1)) >= eff_in;
		out_last = ({1'b0, out_pos_q} + (OW+1)'(1)) >= eff_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_len_q  <= IN_LEN_RST;
			out_len_q <= OUT_LEN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_IN_LENGTH:  in_len_q  <= cfg_data[IN_LEN_W-1:0];
				CFG_OUT_LENGTH: out_len_q <= cfg_data[OUT_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// activation store
	logic        ram_we, ram_re;
	logic [31:0] act;

	assign ram_we = in_acc && in_data.op == OP_LOAD && 32'(in_data.act_index) < MAX_IN;
	assign ram_re = in_acc && in_data.op == OP_WEIGHT;

	bwmv_ram #(
		.WIDTH (32),
		.DEPTH (MAX_IN)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_data.act_index)),
		.wdata (in_data.act_value),
		.re    (ram_re),
		.raddr (in_pos_q),
		.rdata (act)
	);

	// product formation
	logic [31:0] w32;
	logic [7:0]  a_exp, w_exp;
	logic        w_forced, w_zero, a_nan, a_inf, a_zero;
	logic [23:0] a_sig;
	logic [7:0]  w_sig;
	logic [8:0]  ee;

	always_comb begin
		w32      = 32'(w_q) << BF16_SHIFT;
		a_exp    = act[30:23];
		w_exp    = w32[30:23];
		w_forced = (w_q & BF16_EXP_MASK) == BF16_EXP_MASK;
		w_zero   = w_forced || w32[30:0] == '0;
		a_nan    = a_exp == 8'hFF && act[22:0] != '0;
		a_inf    = a_exp == 8'hFF && act[22:0] == '0;
		a_zero   = act[30:0] == '0;
		a_sig    = {a_exp != '0, act[22:0]};
		w_sig    = {w_exp != '0, w32[22:16]};
		ee       = {1'b0, (a_exp == '0) ? 8'd1 : a_exp} + {1'b0, (w_exp == '0) ? 8'd1 : w_exp};
	end

	logic [31:0] mprod_q;
	logic [8:0]  ee_q;
	logic        psign_q, pnan_q, pinf_q, pzero_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			mprod_q <= {8'b0, a_sig} * {24'b0, w_sig};
			ee_q    <= ee;
			psign_q <= act[31] ^ (w_forced ? 1'b0 : w_q[15]);
			pnan_q  <= a_nan || (a_inf && w_zero);
			pinf_q  <= a_inf && !w_zero;
			pzero_q <= !a_nan && !a_inf && (a_zero || w_zero);
		end
	end

	logic [4:0] plz;
	dbl_t       pd;

	always_comb begin
		plz = lzc32(mprod_q);
		pd = '0;
		pd.nan  = pnan_q;
		pd.inf  = pinf_q;
		pd.zero = pzero_q;
		pd.sign = psign_q;
		pd.exp  = EXP_W'({2'b00, ee_q}) - EXP_W'(253) - EXP_W'(plz);
		pd.sig  = {mprod_q << plz, 21'b0};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_NORM) begin
			pd_q <= pd;
		end
	end

	// accumulate
	logic add_done;
	dbl_t add_sum;

	bwmv_dadd u_dadd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_ADD),
		.acc    (acc_q),
		.addend (pd_q),
		.done   (add_done),
		.sum    (add_sum)
	);

	// round the accumulator to fp32
	logic       fr_norm, fr_tiny;
	logic [5:0] rsh;
	logic [SIG_W-1:0] gv;
	logic [23:0] mant;
	logic        grd, stk;
	logic [7:0]  fexp;

	always_comb begin
		fr_norm = acc_q.exp > -11'sd127;
		fr_tiny = acc_q.exp < -11'sd150;
		rsh = fr_norm ? 6'd29 : 6'(-11'sd97 - acc_q.exp);
		gv = acc_q.sig >> (rsh - 6'd1);
		mant = 24'(acc_q.sig >> rsh);
		grd = gv[0];
		stk = |(acc_q.sig & ((SIG_W'(1) << (rsh - 6'd1)) - SIG_W'(1)));
		if (fr_tiny) begin
			mant = '0;
			grd = 1'b0;
			stk = 1'b1;
		end
		fexp = fr_norm ? 8'(acc_q.exp + 11'sd126) : 8'h00;
	end

	logic [23:0] fr_mant_q;
	logic        fr_g_q, fr_st_q, fr_sign_q, fr_nan_q, fr_inf_q, fr_zero_q;
	logic [7:0]  fr_exp_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_FR1) begin
			fr_mant_q <= mant;
			fr_g_q    <= grd;
			fr_st_q   <= stk;
			fr_exp_q  <= fexp;
			fr_sign_q <= acc_q.sign;
			fr_nan_q  <= acc_q.nan;
			fr_inf_q  <= acc_q.inf || (!acc_q.zero && acc_q.exp > 11'sd127);
			fr_zero_q <= acc_q.zero;
		end
	end

	logic        fr_up;
	logic [30:0] fr_word;
	logic [31:0] fr_value;

	always_comb begin
		fr_up = fr_g_q & (fr_st_q | fr_mant_q[0]);
		fr_word = {fr_exp_q, 23'b0} + 31'(fr_mant_q) + 31'(fr_up);
		priority if (fr_nan_q) begin
			fr_value = F32_QNAN;
		end else if (fr_inf_q) begin
			fr_value = {fr_sign_q, F32_INF_MAG};
		end else if (fr_zero_q) begin
			fr_value = {fr_sign_q, 31'b0};
		end else begin
			fr_value = {fr_sign_q, fr_word};
		end
	end

	assign out_ld = (state_q == ST_FR2) && (!out_valid_q || !out_stall);

	// sequencer, positions and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			in_pos_q  <= '0;
			out_pos_q <= '0;
			emit_q    <= 1'b0;
			acc_q     <= '0;
			acc_q.zero <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_data.op == OP_WEIGHT) begin
						state_q <= ST_MUL;
						if (in_last) begin
							in_pos_q  <= '0;
							emit_q    <= 1'b1;
							out_pos_q <= out_last ? '0 : out_pos_q + OW'(1);
						end else begin
							in_pos_q <= in_pos_q + AW'(1);
							emit_q   <= 1'b0;
						end
					end
				end
				ST_MUL:  state_q <= ST_NORM;
				ST_NORM: state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (add_done) begin
						acc_q   <= add_sum;
						state_q <= emit_q ? ST_FR1 : ST_IDLE;
					end
				end
				ST_FR1: begin
					acc_q      <= '0;
					acc_q.zero <= 1'b1;
					state_q    <= ST_FR2;
				end
				ST_FR2: begin
					if (out_ld) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.op == OP_WEIGHT) begin
			w_q <= in_data.weight_raw;
			if (in_last) begin
				idx_q  <= out_pos_q;
				last_q <= out_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_q.out_value   <= fr_value;
			out_q.out_index   <= 12'(idx_q);
			out_q.last_output <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_weight_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_WEIGHT |=> state_q == ST_MUL)
		else $error("weight transaction did not start");
	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_LOAD |=> state_q == ST_IDLE)
		else $error("load transaction left the block busy");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FR2 && (!out_valid || !out_stall) |=> out_valid && state_q == ST_IDLE)
		else $error("rounded result not loaded");

endmodule

[sim/tb_bf16_weight_matvec_top.sv]
// Self-checking testbench for bf16_weight_matvec_top: directed table, a full-store product, then random phases.
// Depends on bwmv_pkg and the block's RTL; predicts each result with a real-valued dot product or the directed table.
module tb_bf16_weight_matvec_top;
	import bwmv_pkg::*;

	typedef struct {
		logic        op;
		logic [31:0] act;
		logic [9:0]  idx;
		logic [15:0] wt;
		bit          typed;
		logic [31:0] val;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_wr_en;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	out_item_t   sums_due[$];
	logic [31:0] act_mem [MAX_IN_DEF];
	real         dot_acc;
	int          in_pos, out_pos, in_len, out_len;
	bit          mismatch_seen;
	bit          take;
	out_item_t   take_data;
	int          stall_cnt;
	row_t        dir_rows [20];

	bf16_weight_matvec_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("bf16_weight_matvec_top verification failed");
		$finish;
	end

	function automatic real f32_to_real(logic [31:0] b);
		logic [63:0] d;
		logic [23:0] mm;
		int          e;
		e = b[30:23];
		if (e == 255) begin
			d = {b[31], 11'h7FF, b[22:0], 29'b0};
		end else if (e == 0) begin
			if (b[22:0] == 0) begin
				d = {b[31], 63'b0};
			end else begin
				mm = {1'b0, b[22:0]};
				e = 897;
				while (!mm[23]) begin
					mm = mm << 1;
					e--;
				end
				d = {b[31], 11'(e), mm[22:0], 29'b0};
			end
		end else begin
			d = {b[31], 11'(e - 127 + 1023), b[22:0], 29'b0};
		end
		return $bitstoreal(d);
	endfunction

	function automatic logic [31:0] real_to_f32(real r);
		logic [63:0] d, sig, q, rest;
		logic [31:0] sgn;
		int          e, s;
		d = $realtobits(r);
		sgn = {d[63], 31'b0};
		if (d[62:52] == 11'h7FF && d[51:0] != 0)
			return F32_QNAN;
		if (d[62:52] == 11'h7FF)
			return sgn | {1'b0, F32_INF_MAG};
		if (d[62:52] == 0)
			return sgn;
		e = int'(d[62:52]) - 1023;
		sig = {11'b0, 1'b1, d[51:0]};
		if (e >= -126) begin
			q = sig >> 29;
			if (sig[28] && ((sig[27:0] != 0) || q[0]))
				q = q + 1;
			if (q[24]) begin
				q = q >> 1;
				e++;
			end
			if (e > 127)
				return sgn | {1'b0, F32_INF_MAG};
			return sgn | {1'b0, 8'(e + 127), q[22:0]};
		end
		s = -e - 97;
		if (s >= 55)
			return sgn;
		q = sig >> s;
		rest = sig & ((64'd1 << (s - 1)) - 1);
		if (sig[s-1] && ((rest != 0) || q[0]))
			q = q + 1;
		return sgn | q[31:0];
	endfunction

	// advance the model by one transaction; returns 1 when a sum is produced
	function automatic bit predict_sum(in_item_t it, output out_item_t res);
		int  eff_in, eff_out;
		real w;
		bit  fin;
		res = '0;
		if (it.op == OP_LOAD) begin
			act_mem[it.act_index] = it.act_value;
			return 1'b0;
		end
		eff_in = (in_len == 0) ? 1 : (in_len > MAX_IN_DEF ? MAX_IN_DEF : in_len);
		eff_out = (out_len == 0) ? 1 : (out_len > MAX_OUT_DEF ? MAX_OUT_DEF : out_len);
		if ((it.weight_raw & BF16_EXP_MASK) == BF16_EXP_MASK)
			w = 0.0;
		else
			w = f32_to_real({it.weight_raw, 16'b0});
		dot_acc = dot_acc + f32_to_real(act_mem[in_pos]) * w;
		if (in_pos + 1 < eff_in) begin
			in_pos++;
			return 1'b0;
		end
		in_pos = 0;
		fin = (out_pos + 1 >= eff_out);
		res.out_value = real_to_f32(dot_acc);
		res.out_index = 12'(out_pos);
		res.last_output = fin;
		dot_acc = 0.0;
		out_pos = fin ? 0 : out_pos + 1;
		return 1'b1;
	endfunction

	function automatic logic [31:0] rand_f32();
		if ($urandom_range(0, 9) < 8)
			return {1'($urandom), 8'(107 + $urandom_range(0, 40)), 23'($urandom)};
		return $urandom;
	endfunction

	function automatic logic [15:0] rand_bf16();
		if ($urandom_range(0, 9) < 8)
			return {1'($urandom), 8'(117 + $urandom_range(0, 20)), 7'($urandom)};
		return 16'($urandom);
	endfunction

	task automatic send_item(in_item_t it, bit typed, logic [31:0] val);
		int        gap, r;
		bit        busy;
		out_item_t res;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(negedge clk);
			busy = in_stall;
			@(posedge clk);
		end while (busy);
		if (predict_sum(it, res)) begin
			if (typed)
				res.out_value = val;
			sums_due.push_back(res);
		end
	endtask

	task automatic write_reg(logic idx, int value);
		in_valid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_IN_LENGTH)
			in_len = value & 'h7FF;
		else
			out_len = value & 'h1FFF;
	endtask

	task automatic send_weight(logic [15:0] wt);
		in_item_t it;
		it = {OP_WEIGHT, 32'($urandom), 10'($urandom), wt};
		send_item(it, 1'b0, '0);
	endtask

	task automatic send_load(logic [9:0] idx, logic [31:0] v);
		in_item_t it;
		it = {OP_LOAD, v, idx, 16'($urandom)};
		send_item(it, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		int r;
		if (stall_cnt == 0) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				out_stall <= 1'b0;
				stall_cnt <= $urandom_range(1, 20);
			end else if (r < 95) begin
				out_stall <= 1'b1;
				stall_cnt <= $urandom_range(1, 3);
			end else begin
				out_stall <= 1'b1;
				stall_cnt <= $urandom_range(10, 40);
			end
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
	end

	always @(negedge clk) begin
		take = arst_n && out_valid && !out_stall;
		take_data = out_data;
	end

	always @(posedge clk) begin
		out_item_t want;
		if (take) begin
			if (sums_due.size() == 0) begin
				$error("unexpected result: out_value %h out_index %0d", take_data.out_value,
					take_data.out_index);
				mismatch_seen = 1'b1;
			end else begin
				want = sums_due.pop_front();
				if (want.out_value !== take_data.out_value) begin
					$error("out_value expected %h actual %h", want.out_value,
						take_data.out_value);
					mismatch_seen = 1'b1;
				end
				if (want.out_index !== take_data.out_index) begin
					$error("out_index expected %0d actual %0d", want.out_index,
						take_data.out_index);
					mismatch_seen = 1'b1;
				end
				if (want.last_output !== take_data.last_output) begin
					$error("last_output expected %0d actual %0d", want.last_output,
						take_data.last_output);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	initial begin
		in_item_t it;
		int       n, phase;
		dir_rows = '{
			'{OP_LOAD,   32'h3F80_0000, 10'd0,    16'h0000, 1'b0, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h3F80, 1'b1, 32'h3F80_0000},
			'{OP_WEIGHT, 32'hFFFF_FFFF, 10'h3FF,  16'h7F80, 1'b1, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'hFFFF, 1'b1, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h0000, 1'b1, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h8000, 1'b1, 32'h0},
			'{OP_LOAD,   32'h7F7F_FFFF, 10'd0,    16'hFFFF, 1'b0, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h4000, 1'b1, 32'h7F80_0000},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'hC000, 1'b1, 32'hFF80_0000},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h3F80, 1'b1, 32'h7F7F_FFFF},
			'{OP_LOAD,   32'h7F80_0000, 10'd0,    16'h0000, 1'b0, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h0000, 1'b1, F32_QNAN},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h7F80, 1'b1, F32_QNAN},
			'{OP_LOAD,   32'h0000_0001, 10'd0,    16'h0000, 1'b0, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h3F00, 1'b1, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h3FC0, 1'b1, 32'h0000_0002},
			'{OP_LOAD,   32'hFFFF_FFFF, 10'h3FF,  16'h0000, 1'b0, 32'h0},
			'{OP_LOAD,   32'h8000_0001, 10'd0,    16'h0000, 1'b0, 32'h0},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h0080, 1'b1, 32'h8000_0000},
			'{OP_WEIGHT, 32'h0,         10'd0,    16'h7F7F, 1'b0, 32'h0}
		};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_IN_LENGTH;
		cfg_data = '0;
		stall_cnt = 0;
		mismatch_seen = 1'b0;
		take = 1'b0;
		dot_acc = 0.0;
		in_pos = 0;
		out_pos = 0;
		in_len = IN_LEN_RST;
		out_len = OUT_LEN_RST;
		foreach (act_mem[i])
			act_mem[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_IN_LENGTH, 1);
		write_reg(CFG_OUT_LENGTH, 2);
		foreach (dir_rows[i]) begin
			it = {dir_rows[i].op, dir_rows[i].act, dir_rows[i].idx, dir_rows[i].wt};
			send_item(it, dir_rows[i].typed, dir_rows[i].val);
		end

		// fill the whole store, then one full-length product
		write_reg(CFG_IN_LENGTH, 2047);
		write_reg(CFG_OUT_LENGTH, 1);
		for (int i = 0; i < MAX_IN_DEF; i++)
			send_load(10'(i), rand_f32());
		for (int i = 0; i < MAX_IN_DEF; i++)
			send_weight(rand_bf16());

		for (phase = 0; phase < 20; phase++) begin
			case ($urandom_range(0, 9))
				0: write_reg(CFG_IN_LENGTH, 0);
				1: write_reg(CFG_IN_LENGTH, 1024);
				default: write_reg(CFG_IN_LENGTH, $urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 9))
				0: write_reg(CFG_OUT_LENGTH, 0);
				1: write_reg(CFG_OUT_LENGTH, 8191);
				2: write_reg(CFG_OUT_LENGTH, 4096);
				default: write_reg(CFG_OUT_LENGTH, $urandom_range(1, 6));
			endcase
			n = (in_len > 8 || in_len == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3 * in_len + 2);
			repeat (n) begin
				if ($urandom_range(0, 99) < 85)
					send_weight(rand_bf16());
				else
					send_load(10'($urandom), rand_f32());
			end
		end

		in_valid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (!mismatch_seen)
			$display("bf16_weight_matvec_top verification clean");
		else
			$display("bf16_weight_matvec_top verification failed");
		$finish;
	end

endmodule

[bf16_weight_matvec_top.f]
design/bwmv_pkg.sv
design/bwmv_ram.sv
design/bwmv_dadd.sv
design/bf16_weight_matvec_top.sv
sim/tb_bf16_weight_matvec_top.sv
